### hw/rtl/slbsm_pkg.sv
// ----------------------------------------------------------------------------
// slbsm_pkg
// Shared types and constants for the serial loaded bank switch mapper:
// access kinds, target codes, register indexes and the mapper state bundle.
// ----------------------------------------------------------------------------
package slbsm_pkg;

    // Fixed memory sizes
    localparam int PRG_RAM_BYTES = 8192;
    localparam int CHR_RAM_BYTES = 8192;
    localparam int PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);
    localparam int CHR_RAM_AW    = $clog2(CHR_RAM_BYTES);

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TARGET_W = 3;
    localparam int OFFSET_W = 18;
    localparam int REG_W    = 5;
    localparam int CFG_W    = 5;

    // Shift register value holding only the marker bit
    localparam logic [REG_W-1:0] SHIFT_EMPTY   = 5'h10;
    // Control register reset value and the PRG mode bits forced by a reset write
    localparam logic [REG_W-1:0] CTRL_RESET    = 5'h0C;
    localparam logic [REG_W-1:0] CTRL_PRG_MODE = 5'h0C;
    localparam logic [CFG_W-1:0] PRG_CNT_RESET = 5'd2;

    // Access kind
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CPU_RD = 2'd0,
        FUNC_CPU_WR = 2'd1,
        FUNC_PPU_RD = 2'd2,
        FUNC_PPU_WR = 2'd3
    } t_func;

    // Result target
    typedef enum logic [TARGET_W-1:0] {
        TGT_NONE      = 3'd0,
        TGT_PRG_ROM   = 3'd1,
        TGT_PRG_RAM   = 3'd2,
        TGT_CHR_ROM   = 3'd3,
        TGT_CHR_RAM   = 3'd4,
        TGT_NAMETABLE = 3'd5,
        TGT_REGISTER  = 3'd6
    } t_target;

    // Internal registers loaded through the shifter
    typedef enum logic [1:0] {
        REG_CONTROL = 2'd0,
        REG_CHR_LOW = 2'd1,
        REG_CHR_HIGH = 2'd2,
        REG_PRG     = 2'd3
    } t_map_reg;

    // Configuration register index
    typedef enum logic {
        CFG_PRG_BANK_COUNT = 1'b0,
        CFG_CHR_IS_RAM     = 1'b1
    } t_cfg_reg;

    // PRG banking modes (control bits 3:2)
    typedef enum logic [1:0] {
        PRG_MODE_32K_A  = 2'd0,
        PRG_MODE_32K_B  = 2'd1,
        PRG_MODE_FIRST  = 2'd2,
        PRG_MODE_LAST   = 2'd3
    } t_prg_mode;

    // Nametable mirroring (control bits 1:0)
    typedef enum logic [1:0] {
        MIR_ONE_LOW  = 2'd0,
        MIR_ONE_HIGH = 2'd1,
        MIR_VERTICAL = 2'd2,
        MIR_HORIZ    = 2'd3
    } t_mirror;

    // Mapper state as seen by the translation logic
    typedef struct packed {
        logic [REG_W-1:0] shift;
        logic [REG_W-1:0] control;
        logic [REG_W-1:0] chr_low;
        logic [REG_W-1:0] chr_high;
        logic [REG_W-1:0] prg;
        logic [CFG_W-1:0] prg_bank_count;
        logic             chr_is_ram;
    } t_map_state;

    // Serial load request from a CPU register write
    typedef struct packed {
        logic     valid;
        logic     clear;
        logic     bit_in;
        t_map_reg index;
    } t_shift_req;

endpackage

### hw/rtl/slbsm_regs.sv
// ----------------------------------------------------------------------------
// slbsm_regs
// Serial shift register, the four loaded registers and the two
// configuration registers.
// ----------------------------------------------------------------------------
module slbsm_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  slbsm_pkg::t_cfg_reg       i_cfg_index,
    input  logic [slbsm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_fire,
    input  slbsm_pkg::t_shift_req     i_shift,
    output slbsm_pkg::t_map_state     o_state
);
    import slbsm_pkg::*;

    t_map_state r_state;
    t_map_state n_state;
    logic [REG_W-1:0] shifted;

    // Work out the next state from a shifter word and a configuration write
    always_comb begin
        n_state = r_state;
        shifted = {i_shift.bit_in, r_state.shift[REG_W-1:1]};
        if (i_fire && i_shift.valid) begin
            if (i_shift.clear) begin
                n_state.shift   = SHIFT_EMPTY;
                n_state.control = r_state.control | CTRL_PRG_MODE;
            end else if (r_state.shift[0]) begin
                n_state.shift = SHIFT_EMPTY;
                unique case (i_shift.index)
                    REG_CONTROL:  n_state.control  = shifted;
                    REG_CHR_LOW:  n_state.chr_low  = shifted;
                    REG_CHR_HIGH: n_state.chr_high = shifted;
                    REG_PRG:      n_state.prg      = shifted;
                    default:      n_state.prg      = shifted;
                endcase
            end else begin
                n_state.shift = shifted;
            end
        end
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_BANK_COUNT: n_state.prg_bank_count = i_cfg_data;
                CFG_CHR_IS_RAM:     n_state.chr_is_ram     = i_cfg_data[0];
                default:            n_state.chr_is_ram     = i_cfg_data[0];
            endcase
        end
    end

    // Hold the state, restore reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.shift          <= SHIFT_EMPTY;
            r_state.control        <= CTRL_RESET;
            r_state.chr_low        <= '0;
            r_state.chr_high       <= '0;
            r_state.prg            <= '0;
            r_state.prg_bank_count <= PRG_CNT_RESET;
            r_state.chr_is_ram     <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

### hw/rtl/slbsm_xlate.sv
// ----------------------------------------------------------------------------
// slbsm_xlate
// Address decode and bank translation for one bus access; also forms the
// serial load request for CPU writes to the register window.
// ----------------------------------------------------------------------------
module slbsm_xlate (
    input  logic [slbsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [slbsm_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [slbsm_pkg::DATA_W-1:0]   i_write_value,
    input  slbsm_pkg::t_map_state          i_state,
    output slbsm_pkg::t_target             o_target,
    output logic [slbsm_pkg::OFFSET_W-1:0] o_offset,
    output logic                           o_write_enable,
    output slbsm_pkg::t_shift_req          o_shift
);
    import slbsm_pkg::*;

    t_func      func;
    logic       is_wr;
    logic       is_cpu;
    logic [ADDR_W-1:0] a;
    t_prg_mode  prg_mode;
    t_mirror    mirror;
    logic [3:0] prg_bank16;
    logic [3:0] last_bank;
    logic [OFFSET_W-1:0] prg_off;
    logic [OFFSET_W-2:0] chr_off;
    logic [REG_W-1:0]    chr_bank;
    logic [10:0]         nt_off;

    assign func     = t_func'(i_func);
    assign a        = i_bus_address;
    assign is_wr    = (func == FUNC_CPU_WR) || (func == FUNC_PPU_WR);
    assign is_cpu   = (func == FUNC_CPU_RD) || (func == FUNC_CPU_WR);
    assign prg_mode = t_prg_mode'(i_state.control[3:2]);
    assign mirror   = t_mirror'(i_state.control[1:0]);
    assign last_bank = i_state.prg_bank_count[3:0] - 4'd1;

    // PRG ROM offset
    always_comb begin
        prg_bank16 = i_state.prg[3:0];
        unique case (prg_mode)
            PRG_MODE_32K_A, PRG_MODE_32K_B: prg_bank16 = {i_state.prg[3:1], a[14]};
            PRG_MODE_FIRST: prg_bank16 = a[14] ? i_state.prg[3:0] : 4'd0;
            PRG_MODE_LAST:  prg_bank16 = a[14] ? last_bank : i_state.prg[3:0];
            default:        prg_bank16 = i_state.prg[3:0];
        endcase
        prg_off = {prg_bank16, a[13:0]};
    end

    // CHR offset: one 8K bank or two 4K banks, chosen by control bit 4
    always_comb begin
        chr_bank = a[12] ? i_state.chr_high : i_state.chr_low;
        if (!i_state.control[4]) begin
            chr_off = {i_state.chr_low[4:1], a[12:0]};
        end else begin
            chr_off = {chr_bank, a[11:0]};
        end
    end

    // Nametable offset; the $3000 mirror leaves bits 11:0 untouched
    always_comb begin
        unique case (mirror)
            MIR_ONE_LOW:  nt_off = {1'b0, a[9:0]};
            MIR_ONE_HIGH: nt_off = {1'b1, a[9:0]};
            MIR_VERTICAL: nt_off = a[10:0];
            MIR_HORIZ:    nt_off = {a[11], a[9:0]};
            default:      nt_off = a[10:0];
        endcase
    end

    // Decode the access
    always_comb begin
        o_target       = TGT_NONE;
        o_offset       = '0;
        o_write_enable = 1'b0;
        o_shift        = '0;
        if (is_cpu) begin
            if (a[15:13] == 3'b011) begin
                o_target       = TGT_PRG_RAM;
                o_offset       = OFFSET_W'(a[PRG_RAM_AW-1:0]);
                o_write_enable = is_wr;
            end else if (a[15]) begin
                if (is_wr) begin
                    o_target       = TGT_REGISTER;
                    o_offset       = OFFSET_W'(a[14:13]);
                    o_write_enable = !i_write_value[7] && i_state.shift[0];
                    o_shift.valid  = 1'b1;
                    o_shift.clear  = i_write_value[7];
                    o_shift.bit_in = i_write_value[0];
                    o_shift.index  = t_map_reg'(a[14:13]);
                end else begin
                    o_target = TGT_PRG_ROM;
                    o_offset = prg_off;
                end
            end
        end else begin
            if (a[15:13] == 3'b000) begin
                if (i_state.chr_is_ram) begin
                    o_target       = TGT_CHR_RAM;
                    o_offset       = OFFSET_W'(chr_off[CHR_RAM_AW-1:0]);
                    o_write_enable = is_wr;
                end else if (!is_wr) begin
                    o_target = TGT_CHR_ROM;
                    o_offset = OFFSET_W'(chr_off);
                end
            end else if (a[15:13] == 3'b001 && a[12:8] != 5'h1F) begin
                o_target       = TGT_NAMETABLE;
                o_offset       = OFFSET_W'(nt_off);
                o_write_enable = is_wr;
            end
        end
    end

endmodule

### hw/rtl/serial_loaded_bank_switch_mapper_unit.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper_unit
// Cartridge bank mapper: translates CPU/PPU bus accesses into a target
// memory and byte offset, and loads its bank registers serially.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_func, i_bus_address, i_write_value
//   out      from block o_out_valid / i_out_stall  o_target, o_offset, o_write_enable
//   cfg      to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// An accepted word is held in the input register, then is translated
// and written to the result register: one word per cycle is sustained
// while the output does not stall. State updates happen as a word moves
// into the result register, so each word sees all earlier writes.
// A stall on the output holds the result register and then the input
// register; the input still takes a word while the input register is empty.
// Reset is synchronous.
// ----------------------------------------------------------------------------
module serial_loaded_bank_switch_mapper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [slbsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [slbsm_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [slbsm_pkg::DATA_W-1:0]   i_write_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [slbsm_pkg::TARGET_W-1:0] o_target,
    output logic [slbsm_pkg::OFFSET_W-1:0] o_offset,
    output logic                           o_write_enable,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [slbsm_pkg::CFG_W-1:0]    i_cfg_data
);
    import slbsm_pkg::*;

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic              r_out_valid;
    t_target           r_target;
    logic [OFFSET_W-1:0] r_offset;
    logic              r_we;

    logic       fire;
    logic       in_take;
    t_map_state state;
    t_shift_req shift_req;
    t_target    x_target;
    logic [OFFSET_W-1:0] x_offset;
    logic       x_we;

    // Advance the input word when the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func <= i_func;
            r_addr <= i_bus_address;
            r_data <= i_write_value;
        end
    end

    slbsm_xlate u_xlate (
        .i_func         (r_func),
        .i_bus_address  (r_addr),
        .i_write_value  (r_data),
        .i_state        (state),
        .o_target       (x_target),
        .o_offset       (x_offset),
        .o_write_enable (x_we),
        .o_shift        (shift_req)
    );

    slbsm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_reg'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_shift     (shift_req),
        .o_state     (state)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_target <= x_target;
            r_offset <= x_offset;
            r_we     <= x_we;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target       = r_target;
    assign o_offset       = r_offset;
    assign o_write_enable = r_we;

endmodule

### tb/serial_loaded_bank_switch_mapper_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper_unit_checker
// Passive scoreboard for the bank mapper. Tracks configuration writes and
// the serially loaded mapper registers, predicts the translation of every
// accepted bus word and compares each result word against it in order.
// ----------------------------------------------------------------------------
module serial_loaded_bank_switch_mapper_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [slbsm_pkg::FUNC_W-1:0]   i_func,
    input  logic [slbsm_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [slbsm_pkg::DATA_W-1:0]   i_write_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [slbsm_pkg::TARGET_W-1:0] i_target,
    input  logic [slbsm_pkg::OFFSET_W-1:0] i_offset,
    input  logic                           i_write_enable,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [slbsm_pkg::CFG_W-1:0]    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_commits
);
    import slbsm_pkg::*;

    typedef struct packed {
        t_target             target;
        logic [OFFSET_W-1:0] offset;
        logic                write_enable;
    } t_map_word;

    // Shadow copy of the mapper registers and configuration
    logic [REG_W-1:0] shift_q;
    logic [REG_W-1:0] ctrl_q;
    logic [REG_W-1:0] chr_lo_q;
    logic [REG_W-1:0] chr_hi_q;
    logic [REG_W-1:0] prg_q;
    logic [CFG_W-1:0] bank_cnt_q;
    logic             chr_ram_q;

    t_map_word expected_maps[$];
    int        fails   = 0;
    int        checked = 0;
    int        commits = 0;

    // Byte offset into CHR memory before any size mask
    function automatic int unsigned chr_offset(logic [ADDR_W-1:0] a);
        if (!ctrl_q[4]) begin
            return (chr_lo_q & 5'h1E) * 32'h1000 + a[12:0];
        end
        return (a[12] ? chr_hi_q : chr_lo_q) * 32'h1000 + a[11:0];
    endfunction

    // Translate one bus word; register writes advance the shadow shifter
    function automatic t_map_word predict_mapping(t_func f, logic [ADDR_W-1:0] a,
                                                  logic [DATA_W-1:0] v);
        t_map_word   r;
        logic        is_wr;
        logic        full;
        int unsigned off;
        int unsigned bank;
        logic [ADDR_W-1:0] na;
        t_prg_mode   mode;

        is_wr          = (f == FUNC_CPU_WR) || (f == FUNC_PPU_WR);
        r.target       = TGT_NONE;
        r.offset       = '0;
        r.write_enable = 1'b0;
        if (f == FUNC_CPU_RD || f == FUNC_CPU_WR) begin
            if (a >= 16'h6000 && a <= 16'h7FFF) begin
                r.target       = TGT_PRG_RAM;
                off            = (a - 16'h6000) & (PRG_RAM_BYTES - 1);
                r.offset       = off[OFFSET_W-1:0];
                r.write_enable = is_wr;
            end else if (a[15] && is_wr) begin
                r.target = TGT_REGISTER;
                r.offset = OFFSET_W'(a[14:13]);
                if (v[7]) begin
                    // Reset write: empty the shifter, force PRG mode 3
                    shift_q = SHIFT_EMPTY;
                    ctrl_q  = ctrl_q | CTRL_PRG_MODE;
                end else begin
                    full    = shift_q[0];
                    shift_q = {v[0], shift_q[REG_W-1:1]};
                    if (full) begin
                        case (t_map_reg'(a[14:13]))
                            REG_CONTROL:  ctrl_q   = shift_q;
                            REG_CHR_LOW:  chr_lo_q = shift_q;
                            REG_CHR_HIGH: chr_hi_q = shift_q;
                            default:      prg_q    = shift_q;
                        endcase
                        shift_q        = SHIFT_EMPTY;
                        r.write_enable = 1'b1;
                        commits++;
                    end
                end
            end else if (a[15]) begin
                r.target = TGT_PRG_ROM;
                mode     = t_prg_mode'(ctrl_q[3:2]);
                if (mode == PRG_MODE_32K_A || mode == PRG_MODE_32K_B) begin
                    off = (prg_q & 5'h0E) * 32'h4000 + a[14:0];
                end else begin
                    // Lower half is $8000-$BFFF, upper half $C000-$FFFF
                    if (!a[14]) begin
                        bank = (mode == PRG_MODE_FIRST) ? 0 : prg_q[3:0];
                    end else begin
                        bank = (mode == PRG_MODE_FIRST) ? prg_q[3:0] : 4'(bank_cnt_q - 1);
                    end
                    off = bank * 32'h4000 + a[13:0];
                end
                r.offset = off[OFFSET_W-1:0];
            end
        end else begin
            if (a <= 16'h1FFF) begin
                if (chr_ram_q) begin
                    r.target       = TGT_CHR_RAM;
                    off            = chr_offset(a) & (CHR_RAM_BYTES - 1);
                    r.offset       = off[OFFSET_W-1:0];
                    r.write_enable = is_wr;
                end else if (!is_wr) begin
                    r.target = TGT_CHR_ROM;
                    off      = chr_offset(a);
                    r.offset = off[OFFSET_W-1:0];
                end
            end else if (a <= 16'h3EFF) begin
                r.target       = TGT_NAMETABLE;
                r.write_enable = is_wr;
                na             = (a >= 16'h3000) ? a - 16'h1000 : a;
                case (t_mirror'(ctrl_q[1:0]))
                    MIR_ONE_LOW:  off = na[9:0];
                    MIR_ONE_HIGH: off = na[9:0] + 32'h400;
                    MIR_VERTICAL: off = na[10:0];
                    default:      off = na[9:0] + ((na < 16'h2800) ? 0 : 32'h400);
                endcase
                r.offset = off[OFFSET_W-1:0];
            end
        end
        return r;
    endfunction

    // Track config, compare result words, queue predictions for input words
    always @(posedge i_clk) begin : watch
        t_map_word want;
        if (!i_rst_n) begin
            shift_q    = SHIFT_EMPTY;
            ctrl_q     = CTRL_RESET;
            chr_lo_q   = '0;
            chr_hi_q   = '0;
            prg_q      = '0;
            bank_cnt_q = PRG_CNT_RESET;
            chr_ram_q  = 1'b0;
            expected_maps.delete();
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_reg'(i_cfg_index) == CFG_PRG_BANK_COUNT) begin
                    bank_cnt_q = i_cfg_data;
                end else begin
                    chr_ram_q = i_cfg_data[0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_maps.size() == 0) begin
                    $display("%0t: result word with none expected: target %0d offset %0h we %0b",
                             $time, i_target, i_offset, i_write_enable);
                    fails++;
                end else begin
                    want = expected_maps.pop_front();
                    checked++;
                    if (i_target !== want.target) begin
                        $display("%0t: target mismatch, expected %0d, got %0d",
                                 $time, want.target, i_target);
                        fails++;
                    end
                    if (i_offset !== want.offset) begin
                        $display("%0t: offset mismatch, expected %0h, got %0h",
                                 $time, want.offset, i_offset);
                        fails++;
                    end
                    if (i_write_enable !== want.write_enable) begin
                        $display("%0t: write_enable mismatch, expected %0b, got %0b",
                                 $time, want.write_enable, i_write_enable);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_maps.push_back(predict_mapping(t_func'(i_func), i_bus_address,
                                                        i_write_value));
            end
        end
        o_pending    <= expected_maps.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_commits    <= commits;
    end

endmodule

### tb/serial_loaded_bank_switch_mapper_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_loaded_bank_switch_mapper_unit_tb
// Stimulus for the bank mapper: a directed sweep of the CPU and PPU maps and
// the serial register load, then random bus traffic with register load
// sequences (whole and broken) under several bank count / CHR type settings
// and three sender/receiver idle mixes. Checking lives in the checker.
// ----------------------------------------------------------------------------
module serial_loaded_bank_switch_mapper_unit_tb;
    import slbsm_pkg::*;

    localparam int NUM_PHASES   = 6;
    localparam int PHASE_WORDS  = 320;
    localparam int HOLD_CYCLES  = 60;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 10;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   bus_address;
    logic [DATA_W-1:0]   write_value;
    logic                out_valid;
    logic                out_stall;
    logic [TARGET_W-1:0] target;
    logic [OFFSET_W-1:0] offset;
    logic                write_enable;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int checked;
    int commits;

    int   words_sent   = 0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_req     = 0;
    int   idle_cycles  = 0;

    int   bank_counts[NUM_PHASES] = '{2, 1, 16, 0, 31, 9};
    logic chr_ram_sel[NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    int   snd_pcts[3]             = '{28, 87, 0};
    int   rcv_pcts[3]             = '{87, 28, 0};

    serial_loaded_bank_switch_mapper_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (func),
        .i_bus_address  (bus_address),
        .i_write_value  (write_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_target       (target),
        .o_offset       (offset),
        .o_write_enable (write_enable),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    serial_loaded_bank_switch_mapper_unit_checker u_map_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (func),
        .i_bus_address  (bus_address),
        .i_write_value  (write_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_target       (target),
        .i_offset       (offset),
        .i_write_enable (write_enable),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_commits      (commits)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off when requested
    initial begin : receiver
        int holds_seen;
        holds_seen = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != holds_seen) begin
                holds_seen = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no progress for %0d cycles, %0d words outstanding",
                         $time, WATCHDOG_MAX, pending);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one bus word, maybe after idle cycles, and hold it until taken
    task automatic send_word(input t_func f, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] v);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        bus_address <= a;
        write_value <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and wait until every expected result word has arrived
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Write both configuration registers on back-to-back cycles
    task automatic set_config(input int count, input logic ram);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRG_BANK_COUNT;
        cfg_data  <= CFG_W'(count);
        @(posedge clk);
        cfg_index <= CFG_CHR_IS_RAM;
        cfg_data  <= {4'($urandom), ram};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One access of any kind, address weighted across the map regions
    task automatic random_access();
        t_func             f;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] v;
        f = t_func'($urandom_range(0, 3));
        v = DATA_W'($urandom_range(0, 255));
        if (f == FUNC_CPU_RD || f == FUNC_CPU_WR) begin
            case ($urandom_range(0, 2))
                0:       a = ADDR_W'($urandom_range(16'h0000, 16'h5FFF));
                1:       a = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
                default: a = ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
            endcase
            // Keep most stray register writes from resetting the shifter
            if (f == FUNC_CPU_WR && a[15] && $urandom_range(0, 3) != 0) begin
                v[7] = 1'b0;
            end
        end else begin
            case ($urandom_range(0, 4))
                0, 1:    a = ADDR_W'($urandom_range(16'h0000, 16'h1FFF));
                2, 3:    a = ADDR_W'($urandom_range(16'h2000, 16'h3EFF));
                default: a = ADDR_W'($urandom_range(16'h3F00, 16'hFFFF));
            endcase
        end
        send_word(f, a, v);
    endtask

    // Shift a 5-bit value into a mapper register, LSB first; a broken load
    // stops early and ends with a reset write
    task automatic load_register(input t_map_reg r, input logic [REG_W-1:0] value,
                                 input bit broken, input bit mixed);
        int                cut;
        int                i;
        logic [DATA_W-1:0] v;
        cut = broken ? $urandom_range(1, 4) : REG_W;
        for (i = 0; i < cut; i++) begin
            if (mixed && $urandom_range(0, 4) == 0) begin
                random_access();
            end
            v    = DATA_W'($urandom_range(0, 127));
            v[0] = value[i];
            send_word(FUNC_CPU_WR, {1'b1, r, 13'($urandom)}, v);
        end
        if (broken) begin
            send_word(FUNC_CPU_WR, ADDR_W'($urandom_range(16'h8000, 16'hFFFF)),
                      DATA_W'($urandom_range(8'h80, 8'hFF)));
        end
    endtask

    initial begin
        int p;
        int phase_end;
        int pick;
        bit hold_done;

        in_valid    <= 1'b0;
        func        <= FUNC_CPU_RD;
        bus_address <= '0;
        write_value <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_PRG_BANK_COUNT;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n       <= 1'b1;
        @(posedge clk);

        for (p = 0; p < NUM_PHASES; p++) begin
            snd_idle_pct = snd_pcts[p / 2];
            rcv_idle_pct = rcv_pcts[p / 2];
            set_config(bank_counts[p], chr_ram_sel[p]);

            if (p == 0) begin
                // Directed sweep of both maps and the serial load
                send_word(FUNC_CPU_RD, 16'h0000, 8'h00);
                send_word(FUNC_CPU_RD, 16'h5FFF, 8'hFF);
                send_word(FUNC_CPU_WR, 16'h0000, 8'h55);
                send_word(FUNC_CPU_RD, 16'h6000, 8'h00);
                send_word(FUNC_CPU_WR, 16'h7FFF, 8'hAA);
                send_word(FUNC_CPU_RD, 16'h8000, 8'h00);
                send_word(FUNC_CPU_RD, 16'hFFFF, 8'h00);
                send_word(FUNC_CPU_WR, 16'h8000, 8'h01);
                send_word(FUNC_CPU_WR, 16'h9FFF, 8'h80);
                load_register(REG_CONTROL, 5'h1B, 1'b0, 1'b0);
                send_word(FUNC_PPU_RD, 16'h0000, 8'h00);
                send_word(FUNC_PPU_RD, 16'h1FFF, 8'h00);
                send_word(FUNC_PPU_WR, 16'h0000, 8'h7F);
                send_word(FUNC_PPU_RD, 16'h2000, 8'h00);
                send_word(FUNC_PPU_WR, 16'h2BFF, 8'h3C);
                send_word(FUNC_PPU_RD, 16'h2C00, 8'h00);
                send_word(FUNC_PPU_RD, 16'h3EFF, 8'h00);
                send_word(FUNC_PPU_RD, 16'h3F00, 8'h00);
                send_word(FUNC_PPU_WR, 16'hFFFF, 8'hFF);
                send_word(FUNC_CPU_RD, 16'hC000, 8'h00);
                send_word(FUNC_CPU_WR, 16'hFFFF, 8'hFF);
            end

            // Random traffic, mostly accesses and register loads
            phase_end = words_sent + PHASE_WORDS;
            hold_done = 1'b0;
            while (words_sent < phase_end) begin
                if (!hold_done && words_sent >= phase_end - PHASE_WORDS + 40) begin
                    hold_req++;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    load_register(t_map_reg'($urandom_range(0, 3)),
                                  REG_W'($urandom_range(0, 31)),
                                  $urandom_range(0, 6) == 0, 1'b1);
                end else if (pick < 25) begin
                    send_word(FUNC_CPU_WR, ADDR_W'($urandom_range(16'h8000, 16'hFFFF)),
                              DATA_W'($urandom_range(8'h80, 8'hFF)));
                end else if (pick < 27) begin
                    drain();
                end else begin
                    random_access();
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bus words over %0d bank count / CHR type settings and 3 idle mixes;",
                 words_sent, NUM_PHASES);
        $display("checked %0d result words, %0d serial register commits.", checked, commits);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
